### design/ptr_pkg.sv
`timescale 1ns / 1ps

package ptr_pkg;

    // Number of weights: the bias weight followed by the four feature weights.
    localparam int NUM_WEIGHTS = 5;
    localparam int FEATURE_WIDTH = 16;
    localparam int WEIGHT_WIDTH_DEF = 32;

    // The bias input is fixed at 1.0 in Q4.12.
    localparam logic [FEATURE_WIDTH-1:0] BIAS_ONE = 16'd4096;

    localparam logic [7:0] UPDATE_LIMIT_RESET = 8'd100;
    localparam logic [15:0] TEST_COUNT_MAX = 16'hFFFF;

    localparam logic [1:0] FUNC_TRAIN = 2'd0;
    localparam logic [1:0] FUNC_TEST = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic negative;
        logic zero;
    } t_score_sts;

endpackage

### design/ptr_score.sv
`timescale 1ns / 1ps

module ptr_score #(
    parameter int WEIGHT_WIDTH = ptr_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic [ptr_pkg::NUM_WEIGHTS-1:0][WEIGHT_WIDTH-1:0]           i_weights,
    input  logic [ptr_pkg::NUM_WEIGHTS-1:0][ptr_pkg::FEATURE_WIDTH-1:0] i_features,
    output ptr_pkg::t_score_sts                                         o_sts
);

    localparam int PROD_WIDTH = WEIGHT_WIDTH + ptr_pkg::FEATURE_WIDTH;
    localparam int SUM_WIDTH = PROD_WIDTH + $clog2(ptr_pkg::NUM_WEIGHTS);

    logic signed [PROD_WIDTH-1:0] w_prod [ptr_pkg::NUM_WEIGHTS];
    logic signed [SUM_WIDTH-1:0]  w_sum;

    always_comb begin
        for (int i = 0; i < ptr_pkg::NUM_WEIGHTS; i++) begin
            w_prod[i] = $signed(i_weights[i]) * $signed(i_features[i]);
        end
    end

    // The score is kept at full width, so its sign is exact.
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < ptr_pkg::NUM_WEIGHTS; i++) begin
            w_sum = w_sum + SUM_WIDTH'(w_prod[i]);
        end
    end

    assign o_sts.negative = w_sum[SUM_WIDTH-1];
    assign o_sts.zero = (w_sum == '0);

endmodule

### design/ptr_wlane.sv
`timescale 1ns / 1ps

module ptr_wlane #(
    parameter int WEIGHT_WIDTH = ptr_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic [WEIGHT_WIDTH-1:0]           i_weight,
    input  logic [ptr_pkg::FEATURE_WIDTH-1:0] i_feature,
    input  logic                              i_positive,
    output logic [WEIGHT_WIDTH-1:0]           o_weight
);

    localparam logic [WEIGHT_WIDTH-1:0] W_MAX = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
    localparam logic [WEIGHT_WIDTH-1:0] W_MIN = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};

    logic signed [WEIGHT_WIDTH:0] w_x;
    logic signed [WEIGHT_WIDTH:0] w_delta;
    logic signed [WEIGHT_WIDTH:0] w_sum;

    assign w_x = (WEIGHT_WIDTH+1)'($signed(i_feature));
    assign w_delta = i_positive ? w_x : -w_x;
    assign w_sum = (WEIGHT_WIDTH+1)'($signed(i_weight)) + w_delta;

    // One guard bit is enough: the sum has overflowed when it differs from the sign bit.
    always_comb begin
        if (w_sum[WEIGHT_WIDTH] != w_sum[WEIGHT_WIDTH-1]) begin
            o_weight = w_sum[WEIGHT_WIDTH] ? W_MIN : W_MAX;
        end else begin
            o_weight = w_sum[WEIGHT_WIDTH-1:0];
        end
    end

endmodule

### design/perceptron_training_step.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// in        request    i_in_valid / o_in_stall    i_func, i_feature_one..four, i_label_positive
// out       result     o_out_valid / i_out_stall  o_mistake .. o_test_mistakes
// cfg       write      i_cfg_we                   i_cfg_wdata (update limit)
//
// One request per cycle is taken while o_in_stall is low; it passes the input register, then the result register.
// The dot product and the weight update sit between the input and result registers,
// so each request sees the weights left by the one before it.
// A stalled result holds the result register; the input register still takes one
// further request, after which o_in_stall rises.
// Reset clears the weights and both counters and sets the update limit to 100.

module perceptron_training_step #(
    parameter int WEIGHT_WIDTH = ptr_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic signed [15:0] i_feature_one,
    input  logic signed [15:0] i_feature_two,
    input  logic signed [15:0] i_feature_three,
    input  logic signed [15:0] i_feature_four,
    input  logic        i_label_positive,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_mistake,
    output logic        o_weights_changed,
    output logic [7:0]  o_corrections_done,
    output logic        o_training_finished,
    output logic [15:0] o_test_mistakes
);

    localparam int N = ptr_pkg::NUM_WEIGHTS;
    localparam int FW = ptr_pkg::FEATURE_WIDTH;

    // Input register
    logic           r_in_vld;
    logic [1:0]     r_func;
    logic [FW-1:0]  r_f1, r_f2, r_f3, r_f4;
    logic           r_label;

    // State
    logic [N-1:0][WEIGHT_WIDTH-1:0] r_weights, n_weights;
    logic [7:0]     r_corr, n_corr;
    logic [15:0]    r_tmc, n_tmc;
    logic [7:0]     r_limit;

    // Result register
    logic           r_out_vld;
    logic           r_mistake, n_mistake;
    logic           r_changed, n_changed;
    logic [7:0]     r_corr_out;
    logic           r_fin, n_fin;
    logic [15:0]    r_tmc_out;

    logic w_fire;
    logic w_accept;
    logic w_train, w_test, w_clear;
    logic [N-1:0][FW-1:0] w_x;
    logic [N-1:0][WEIGHT_WIDTH-1:0] w_upd;
    ptr_pkg::t_score_sts w_sts;

    assign w_fire = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_fire;
    assign w_accept = i_in_valid && !o_in_stall;

    assign w_x[0] = ptr_pkg::BIAS_ONE;
    assign w_x[1] = r_f1;
    assign w_x[2] = r_f2;
    assign w_x[3] = r_f3;
    assign w_x[4] = r_f4;

    ptr_score #(
        .WEIGHT_WIDTH(WEIGHT_WIDTH)
    ) u_score (
        .i_weights  (r_weights),
        .i_features (w_x),
        .o_sts      (w_sts)
    );

    for (genvar g = 0; g < N; g++) begin : g_lane
        ptr_wlane #(
            .WEIGHT_WIDTH(WEIGHT_WIDTH)
        ) u_wlane (
            .i_weight   (r_weights[g]),
            .i_feature  (w_x[g]),
            .i_positive (r_label),
            .o_weight   (w_upd[g])
        );
    end

    assign w_train = (r_func == ptr_pkg::FUNC_TRAIN);
    assign w_test = (r_func == ptr_pkg::FUNC_TEST);
    assign w_clear = (r_func == ptr_pkg::FUNC_CLEAR);

    always_comb begin
        // A zero score is a mistake for either label.
        if (w_train || w_test) begin
            n_mistake = r_label ? (w_sts.negative || w_sts.zero) : !w_sts.negative;
        end else begin
            n_mistake = 1'b0;
        end
        n_changed = w_train && n_mistake && (r_corr < r_limit);

        n_weights = r_weights;
        n_corr = r_corr;
        n_tmc = r_tmc;
        if (w_clear) begin
            n_weights = '0;
            n_corr = '0;
            n_tmc = '0;
        end else if (n_changed) begin
            n_weights = w_upd;
            n_corr = r_corr + 8'd1;
        end else if (w_test && n_mistake && (r_tmc != ptr_pkg::TEST_COUNT_MAX)) begin
            n_tmc = r_tmc + 16'd1;
        end
        n_fin = (n_corr >= r_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_func;
            r_f1 <= i_feature_one;
            r_f2 <= i_feature_two;
            r_f3 <= i_feature_three;
            r_f4 <= i_feature_four;
            r_label <= i_label_positive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights <= '0;
            r_corr <= '0;
            r_tmc <= '0;
        end else if (w_fire) begin
            r_weights <= n_weights;
            r_corr <= n_corr;
            r_tmc <= n_tmc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ptr_pkg::UPDATE_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_mistake <= n_mistake;
            r_changed <= n_changed;
            r_corr_out <= n_corr;
            r_fin <= n_fin;
            r_tmc_out <= n_tmc;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_mistake = r_mistake;
    assign o_weights_changed = r_changed;
    assign o_corrections_done = r_corr_out;
    assign o_training_finished = r_fin;
    assign o_test_mistakes = r_tmc_out;

`ifndef SYNTHESIS
    a_changed_is_mistake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_weights_changed |-> o_mistake)
        else $error("weights changed without a mistake");

    a_changed_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_weights_changed |-> o_corrections_done != 8'd0)
        else $error("correction reported with a zero count");

    a_corr_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_corr != $past(r_corr))
        |-> (r_corr == $past(r_corr) + 8'd1) || (r_corr == 8'd0))
        else $error("correction count moved by more than one");

    a_test_keeps_weights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_test |=> r_weights == $past(r_weights))
        else $error("test request altered the weights");
`endif

endmodule
